@@ hw/rtl/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types of the first-fit heap allocator: request and result words,
// status codes, controller states and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int FieldW = 10;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef struct packed {
    req_t              req_type;
    logic [FieldW-1:0] alloc_units;
    logic [FieldW-1:0] free_addr;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [FieldW-1:0] data_addr;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_WALK,
    S_ASPL1,
    S_ASPL2,
    S_ASPL3,
    S_FHDR,
    S_FNXT,
    S_FPRV,
    S_FLNK,
    S_FLNK2
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WALK,
    OP_ASPL1,
    OP_ASPL2,
    OP_ASPL3,
    OP_FHDR,
    OP_FNXT,
    OP_FPRV,
    OP_FLNK,
    OP_FLNK2
  } op_t;

  typedef struct packed {
    logic    clr_step;
    logic    load;
    op_t     op;
    logic    resp;
    status_t resp_status;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hdr_ok;
    logic fit;
    logic nxt_in;
    logic fhdr_ok;
  } sts_t;

endpackage

@@ hw/rtl/ffha_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller of the heap allocator: sequences the clearing pass, the
// first-fit walk and split of an allocate, and the merge steps of a free.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          req_free,
  input  ffha_pkg::sts_t sts,
  output logic          busy,
  output ffha_pkg::cmd_t cmd
);
  import ffha_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    busy            = 1'b1;
    cmd.clr_step    = 1'b0;
    cmd.load        = 1'b0;
    cmd.op          = OP_NONE;
    cmd.resp        = 1'b0;
    cmd.resp_status = ST_OK;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = req_free ? S_FHDR : S_WALK;
        end
      end
      S_WALK: begin
        cmd.op = OP_WALK;
        if (!sts.hdr_ok) begin
          cmd.resp        = 1'b1;
          cmd.resp_status = ST_NO_FIT;
          state_nxt       = S_IDLE;
        end else if (sts.fit) begin
          state_nxt = S_ASPL1;
        end else if (!sts.nxt_in) begin
          cmd.resp        = 1'b1;
          cmd.resp_status = ST_NO_FIT;
          state_nxt       = S_IDLE;
        end
      end
      S_ASPL1: begin
        cmd.op    = OP_ASPL1;
        state_nxt = S_ASPL2;
      end
      S_ASPL2: begin
        cmd.op    = OP_ASPL2;
        state_nxt = S_ASPL3;
      end
      S_ASPL3: begin
        cmd.op    = OP_ASPL3;
        cmd.resp  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FHDR: begin
        cmd.op = OP_FHDR;
        if (!sts.fhdr_ok) begin
          cmd.resp        = 1'b1;
          cmd.resp_status = ST_BAD_ADDR;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_FNXT;
        end
      end
      S_FNXT: begin
        cmd.op    = OP_FNXT;
        state_nxt = S_FPRV;
      end
      S_FPRV: begin
        cmd.op    = OP_FPRV;
        state_nxt = S_FLNK;
      end
      S_FLNK: begin
        cmd.op    = OP_FLNK;
        state_nxt = S_FLNK2;
      end
      S_FLNK2: begin
        cmd.op    = OP_FLNK2;
        cmd.resp  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp |=> !cmd.resp)
    else $error("two responses in a row");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> busy)
    else $error("accepted word did not make the block busy");

  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (!cmd.resp && !cmd.load))
    else $error("activity during clearing pass");

endmodule

@@ hw/rtl/ffha_dp.sv @@
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath of the heap allocator: header memory (start, used, prev, size per
// unit), walk and merge address arithmetic, clearing counter and result
// register.
// ----------------------------------------------------------------------------
module ffha_dp #(
  parameter int HEAP_UNITS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffha_pkg::cmd_t      cmd,
  input  ffha_pkg::in_word_t  in_word,
  output ffha_pkg::sts_t      sts,
  output logic                out_valid,
  output ffha_pkg::out_word_t out_word
);
  import ffha_pkg::*;

  localparam int AW = (HEAP_UNITS > 1) ? $clog2(HEAP_UNITS) : 1;
  localparam int XW = (AW + 2 > FieldW + 2) ? AW + 2 : FieldW + 2;
  localparam logic [XW-1:0] HEAP_X = XW'(HEAP_UNITS);
  localparam logic [AW-1:0] LAST_A = AW'(HEAP_UNITS - 1);

  typedef struct packed {
    logic          start;
    logic          used;
    logic [AW-1:0] prev;
    logic [AW-1:0] size;
  } hdr_t;

  hdr_t mem [HEAP_UNITS];
  hdr_t rd_r;

  logic [AW-1:0] clr_r;
  logic [AW-1:0] a_r;
  logic [AW-1:0] s_r;
  logic [AW-1:0] pv_r;
  logic [AW-1:0] nx_r;
  logic          nxv_r;
  logic [FieldW:0] need_r;
  logic          bad_r;
  logic          mn_r;
  logic          mp_r;
  logic          lk_r;
  hdr_t          lkw_r;
  logic [AW-1:0] psz_r;
  logic [AW-1:0] pprev_r;
  logic          out_valid_r;
  out_word_t     out_word_r;

  logic [XW-1:0] h_x;
  logic [XW-1:0] sum_x;
  logic [XW-1:0] nn_x;
  logic [XW-1:0] r_x;
  logic [XW-1:0] a1_x;
  logic          merge_n;
  logic          merge_p;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  hdr_t          wdata;
  hdr_t          init_w;

  assign h_x     = XW'(in_word.free_addr) - XW'(1);
  assign sum_x   = XW'(a_r) + XW'(rd_r.size);
  assign nn_x    = XW'(a_r) + XW'(s_r);
  assign r_x     = XW'(a_r) + XW'(need_r);
  assign a1_x    = XW'(a_r) + XW'(1);
  assign merge_n = nxv_r && rd_r.start && !rd_r.used;
  assign merge_p = (a_r != '0) && rd_r.start && !rd_r.used;

  assign sts.clr_done = (clr_r == LAST_A);
  assign sts.hdr_ok   = rd_r.start && (rd_r.size != '0);
  assign sts.fit      = !rd_r.used && (XW'(rd_r.size) > XW'(need_r));
  assign sts.nxt_in   = (sum_x < HEAP_X);
  assign sts.fhdr_ok  = !bad_r && rd_r.start && rd_r.used;

  always_comb begin
    init_w = '0;
    if (clr_r == '0) begin
      init_w.start = 1'b1;
      init_w.size  = LAST_A;
    end
  end

  // read address
  always_comb begin
    raddr = '0;
    if (cmd.load) begin
      raddr = (in_word.req_type == REQ_FREE) ? h_x[AW-1:0] : '0;
    end else begin
      case (cmd.op)
        OP_WALK: raddr = sum_x[AW-1:0];
        OP_FHDR: raddr = sum_x[AW-1:0];
        OP_FNXT: raddr = pv_r;
        OP_FPRV: raddr = nn_x[AW-1:0];
        default: raddr = '0;
      endcase
    end
  end

  // write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_r;
      wdata = init_w;
    end else begin
      case (cmd.op)
        OP_ASPL1: begin
          we    = 1'b1;
          waddr = a_r;
          wdata = '{start: 1'b1, used: 1'b1, prev: pv_r, size: AW'(need_r)};
        end
        OP_ASPL2: begin
          we    = 1'b1;
          waddr = r_x[AW-1:0];
          wdata = '{start: 1'b1, used: 1'b0, prev: a_r,
                    size: s_r - AW'(need_r)};
        end
        OP_ASPL3: begin
          we         = lk_r;
          waddr      = nx_r;
          wdata      = lkw_r;
          wdata.prev = r_x[AW-1:0];
        end
        OP_FNXT: begin
          we    = merge_n;
          waddr = nx_r;
          wdata = '0;
        end
        OP_FPRV: begin
          we    = 1'b1;
          waddr = a_r;
          wdata = merge_p ? hdr_t'('0)
                          : hdr_t'{start: 1'b1, used: 1'b0, prev: pv_r, size: s_r};
        end
        OP_FLNK: begin
          we    = mp_r;
          waddr = pv_r;
          wdata = '{start: 1'b1, used: 1'b0, prev: pprev_r, size: psz_r};
        end
        OP_FLNK2: begin
          we         = lk_r;
          waddr      = nx_r;
          wdata      = lkw_r;
          wdata.prev = mp_r ? pv_r : a_r;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step && !sts.clr_done) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      need_r <= (FieldW + 1)'(in_word.alloc_units) + (FieldW + 1)'(1);
      bad_r  <= (in_word.free_addr == '0) || (h_x >= HEAP_X);
      a_r    <= (in_word.req_type == REQ_FREE) ? h_x[AW-1:0] : '0;
    end else begin
      case (cmd.op)
        OP_WALK: begin
          if (sts.fit) begin
            s_r   <= rd_r.size;
            pv_r  <= rd_r.prev;
            nx_r  <= sum_x[AW-1:0];
            nxv_r <= sts.nxt_in;
          end else begin
            a_r <= sum_x[AW-1:0];
          end
        end
        OP_ASPL1: begin
          lk_r  <= nxv_r && rd_r.start;
          lkw_r <= rd_r;
        end
        OP_FHDR: begin
          s_r   <= rd_r.size;
          pv_r  <= rd_r.prev;
          nx_r  <= sum_x[AW-1:0];
          nxv_r <= sts.nxt_in;
        end
        OP_FNXT: begin
          mn_r <= merge_n;
          if (merge_n) begin
            s_r <= s_r + rd_r.size;
          end
        end
        OP_FPRV: begin
          mp_r    <= merge_p;
          psz_r   <= rd_r.size + s_r;
          pprev_r <= rd_r.prev;
          nx_r    <= nn_x[AW-1:0];
          nxv_r   <= (nn_x < HEAP_X);
        end
        OP_FLNK: begin
          lk_r  <= (mn_r || mp_r) && nxv_r && rd_r.start;
          lkw_r <= rd_r;
        end
        default: begin
          lk_r <= lk_r;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_word_r.status    <= cmd.resp_status;
      out_word_r.data_addr <= (cmd.op == OP_ASPL3) ? a1_x[FieldW-1:0] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status != ST_OK) |-> (out_word_r.data_addr == '0))
    else $error("failed request returned an address");

  a_merge_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FNXT && merge_n) |-> (nx_r != pv_r))
    else $error("successor drop collides with predecessor read");

endmodule

@@ hw/rtl/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with coalescing of free neighbours, built as a
// controller and a datapath around one header memory of HEAP_UNITS entries.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the header memory, one
// entry per cycle, with busy high. A word is taken when start is high and
// busy is low; busy then stays high until the result strobe. An allocate
// walks the segment headers, up to HEAP_UNITS of them, with one memory read
// per cycle, then writes the split in S_ASPL1, S_ASPL2 and S_ASPL3, or it
// answers from S_WALK when no segment fits. A free runs S_FHDR to S_FLNK2,
// or answers from S_FHDR when the address is rejected. out_valid is high
// for a single cycle; out_word keeps the result until the next result.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int HEAP_UNITS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ffha_pkg::in_word_t  in_word,
  output logic                out_valid,
  output ffha_pkg::out_word_t out_word
);
  import ffha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_free (in_word.req_type == REQ_FREE),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  ffha_dp #(
    .HEAP_UNITS (HEAP_UNITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
